// ===== src/fbp_pkg.sv =====
package fbp_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned VB_W   = 10;
    localparam int unsigned EC_W   = 16;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned ENT_W  = VB_W + EC_W;

    localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] K_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] K_POP    = 3'd2;
    localparam logic [KIND_W-1:0] K_MIN    = 3'd3;
    localparam logic [KIND_W-1:0] K_LOOKUP = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SHWR  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ===== src/free_block_pool_with_min_wear_unit.sv =====
// Free flash block pool with least-worn search.
// Command channel: drive i_kind, i_vb_index and i_erase_count with start high;
// the command is taken at a rising edge where busy is low. busy then stays
// high until the result transfer: o_done is high for exactly one cycle with
// o_status, o_found_index, o_found_erase_count and o_entry_count valid.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// Entries live in a memory with one write port and one registered read port.
// Append, any command on an empty pool and unused kinds go straight to the
// result. Look up and least-worn search read one entry per cycle. Remove and
// pop first scan to the hit, then move each later entry down one place (read,
// then write), so the worst case is a hit at the head. A new command can be
// taken at the edge that takes the result.
// After reset the pool is empty; no clearing pass is needed because only the
// first fill entries are ever used. One command is handled at a time.
module free_block_pool_with_min_wear_unit
    import fbp_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [VB_W-1:0]     i_vb_index,
    input  logic [EC_W-1:0]     i_erase_count,
    output logic                o_done,
    output logic [ST_W-1:0]     o_status,
    output logic [VB_W-1:0]     o_found_index,
    output logic [EC_W-1:0]     o_found_erase_count,
    output logic [CNT_W-1:0]    o_entry_count
);

    localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned FW = $clog2(POOL_DEPTH + 1);
    localparam logic [FW-1:0] FULL_V = FW'(POOL_DEPTH);

    logic [ENT_W-1:0] r_mem [POOL_DEPTH];
    logic [ENT_W-1:0] r_rd;

    t_state           r_state;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_pos;
    logic [FW-1:0]    r_rdpos;
    logic             r_rdv;
    logic [KIND_W-1:0] r_kind;
    logic [VB_W-1:0]  r_idx;
    logic [ENT_W-1:0] r_hit;
    logic             r_have;
    logic [ST_W-1:0]  r_st;
    logic             r_we;
    logic [AW-1:0]    r_wa;
    logic [ENT_W-1:0] r_wd;

    logic [AW-1:0]    w_ra;

    assign busy = (r_state != S_IDLE);
    assign w_ra = r_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_wa] <= r_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pos   <= '0;
            r_we    <= 1'b0;
            r_rdv   <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_we   <= 1'b0;
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind <= i_kind;
                        r_idx  <= i_vb_index;
                        r_have <= 1'b0;
                        r_st   <= ST_OK;
                        r_pos  <= '0;
                        r_rdv  <= 1'b0;
                        r_state <= S_DONE;
                        if (i_kind == K_APPEND) begin
                            if (r_fill >= FULL_V) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_we   <= 1'b1;
                                r_wa   <= r_fill[AW-1:0];
                                r_wd   <= {i_vb_index, i_erase_count};
                                r_fill <= r_fill + 1'b1;
                            end
                        end else if (i_kind == K_REMOVE || i_kind == K_POP ||
                                     i_kind == K_MIN || i_kind == K_LOOKUP) begin
                            if (r_fill == '0) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_state <= S_SCAN;
                                r_pos   <= FW'(1);
                                r_rdpos <= '0;
                                r_rdv   <= 1'b1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // r_rd holds entry r_rdpos when r_rdv is set.
                    r_rdpos <= r_pos;
                    r_rdv   <= (r_pos < r_fill);
                    r_pos   <= r_pos + 1'b1;
                    if (r_rdv) begin
                        if (r_kind == K_MIN) begin
                            if (!r_have || r_rd[EC_W-1:0] < r_hit[EC_W-1:0]) begin
                                r_hit <= r_rd;
                            end
                            r_have <= 1'b1;
                        end else if (r_kind == K_POP ||
                                     r_rd[ENT_W-1:EC_W] == r_idx) begin
                            r_hit  <= r_rd;
                            r_have <= 1'b1;
                            if (r_kind == K_LOOKUP) begin
                                r_state <= S_DONE;
                            end else begin
                                r_pos   <= r_rdpos + 1'b1;
                                r_rdpos <= r_rdpos;
                                r_state <= S_SHIFT;
                            end
                        end
                    end else begin
                        if (r_kind != K_MIN) begin
                            r_st <= ST_NOT_FOUND;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    // Read of entry r_pos is in flight; r_rdpos is the hole.
                    if (r_pos >= r_fill) begin
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_we    <= 1'b1;
                    r_wa    <= r_rdpos[AW-1:0];
                    r_wd    <= r_rd;
                    r_rdpos <= r_pos;
                    r_pos   <= r_pos + 1'b1;
                    r_state <= S_SHIFT;
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    o_status <= r_st;
                    o_found_index       <= r_have ? r_hit[ENT_W-1:EC_W] : '0;
                    o_found_erase_count <= r_have ? r_hit[EC_W-1:0] : '0;
                    o_entry_count       <= CNT_W'(r_fill);
                    r_pos   <= '0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_V)
        else $error("fill above depth");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !$past(busy) |-> $stable(r_fill))
        else $error("fill changed while idle");
    a_have_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_found_index == '0 && o_found_erase_count == '0)
        else $error("data on error status");

endmodule
